/* sv/psd_pkg.sv */
`timescale 1ns / 1ps

package psd_pkg;

	// Field widths
	localparam int DATA_W     = 8;
	localparam int CH_W       = 3;
	localparam int IDX_W      = 10;
	localparam int ADDR_W     = 13;
	localparam int LEN_W      = 8;
	localparam int STRIDE_W   = 4;
	localparam int ECNT_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Largest values the config registers can hold
	localparam int STRIDE_REG_MAX = (1 << STRIDE_W) - 1;
	localparam int ECNT_REG_MAX   = (1 << ECNT_W) - 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEM_COUNT = 2'd1;

	// Register reset values
	localparam logic [STRIDE_W-1:0] STRIDE_RST = 4'd4;
	localparam logic [ECNT_W-1:0]   ECNT_RST   = 11'd1024;

	// PackBits header codes
	localparam logic [DATA_W-1:0] HDR_NOP      = 8'd128;
	localparam logic [LEN_W-1:0]  REP_LEN_BIAS = 8'd2;

	// Depth of the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Parser state
	typedef enum logic [2:0] {
		MODE_HEADER  = 3'b001,
		MODE_LITERAL = 3'b010,
		MODE_REPEAT  = 3'b100
	} mode_t;

	// One parsed byte, front to back
	typedef struct packed {
		logic              run;
		logic              new_stream;
		logic [CH_W-1:0]   channel;
		logic [DATA_W-1:0] value;
		logic [LEN_W-1:0]  length;
	} q_entry_t;

endpackage

/* sv/psd_in_if.sv */
`timescale 1ns / 1ps

interface psd_in_if import psd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              first;
	logic [CH_W-1:0]   channel;

	modport source (output valid, output data_byte, output first, output channel, input ready);
	modport sink (input valid, input data_byte, input first, input channel, output ready);
endinterface

/* sv/psd_out_if.sv */
`timescale 1ns / 1ps

interface psd_out_if import psd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] run_value;
	logic [IDX_W-1:0]  element_index;
	logic [ADDR_W-1:0] byte_address;
	logic [LEN_W-1:0]  run_length;
	logic              stream_done;
	logic              overrun;

	modport source (output valid, output run_value, output element_index, output byte_address,
		output run_length, output stream_done, output overrun, input ready);
	modport sink (input valid, input run_value, input element_index, input byte_address,
		input run_length, input stream_done, input overrun, output ready);
endinterface

/* sv/psd_cfg_if.sv */
`timescale 1ns / 1ps

interface psd_cfg_if import psd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/packbits_stride_decoder_core.sv */
`timescale 1ns / 1ps

// PackBits run decoder with strided destination addressing.
// stream: one compressed byte per word (data_byte, first, channel). A word with
//   first set starts a new stream on the given channel and is its header byte.
// runs: one word per decoded run: value, first element index, byte address
//   (channel + index * stride), run length, stream_done and overrun.
// cfg: register writes (index 0 stride, index 1 element_count); always ready.
//   Write only while no bytes are in flight.
// Path: a byte that produces a run is written into the queue when it is
//   accepted, then taken into the output register once that register is
//   free. Throughput: one byte per cycle while runs does not stall and the
//   queue is not full, set by the count/clip/address update in the back end.
// Header bytes, no-op headers and bytes after a finished stream give no word.
// Reset: parser expects a header, stream on channel 0 with no elements
//   written, stride 4, element_count 1024.
// A stall on runs holds the output word; up to four parsed bytes collect in
//   the queue behind it, then stream.ready drops.
module packbits_stride_decoder_core import psd_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int MAX_STRIDE   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	psd_in_if.sink     stream,
	psd_out_if.source  runs,
	psd_cfg_if.sink    cfg
);

	logic [STRIDE_W-1:0] stride_q;
	logic [ECNT_W-1:0]   elem_count_q;

	logic     push_valid, push_ready, pop_valid, pop;
	q_entry_t push_entry, pop_entry;

	// Config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q     <= STRIDE_RST;
			elem_count_q <= ECNT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_STRIDE:     stride_q     <= cfg.data[STRIDE_W-1:0];
				CFG_ELEM_COUNT: elem_count_q <= cfg.data[ECNT_W-1:0];
				default: ;
			endcase
		end
	end

	psd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	psd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	psd_back #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.MAX_STRIDE   (MAX_STRIDE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop),
		.stride     (stride_q),
		.elem_count (elem_count_q),
		.runs       (runs)
	);

endmodule

/* sv/psd_front.sv */
`timescale 1ns / 1ps

module psd_front import psd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	psd_in_if.sink   stream,
	output logic     push_valid,
	output q_entry_t push_entry,
	input  logic     push_ready
);

	mode_t             mode_q, mode_d, eff_mode;
	logic [LEN_W-1:0]  lit_left_q, lit_left_d, lit_next;
	logic [LEN_W-1:0]  rep_len_q, rep_len_d;
	logic              accept;

	assign stream.ready = push_ready;
	assign accept       = stream.valid && push_ready;
	assign push_valid   = accept;

	// Header / literal / repeat parsing of one byte
	always_comb begin
		eff_mode   = stream.first ? MODE_HEADER : mode_q;
		mode_d     = mode_q;
		lit_left_d = lit_left_q;
		rep_len_d  = rep_len_q;
		lit_next   = lit_left_q - LEN_W'(lit_left_q != '0);

		push_entry.run        = 1'b0;
		push_entry.new_stream = stream.first;
		push_entry.channel    = stream.channel;
		push_entry.value      = stream.data_byte;
		push_entry.length     = LEN_W'(1);

		case (eff_mode)
			MODE_HEADER: begin
				if (stream.data_byte < HDR_NOP) begin
					lit_left_d = LEN_W'(stream.data_byte) + LEN_W'(1);
					mode_d     = MODE_LITERAL;
				end else if (stream.data_byte > HDR_NOP) begin
					// 257 - header
					rep_len_d = LEN_W'(~stream.data_byte) + REP_LEN_BIAS;
					mode_d    = MODE_REPEAT;
				end else begin
					mode_d = MODE_HEADER;
				end
			end
			MODE_LITERAL: begin
				lit_left_d     = lit_next;
				mode_d         = (lit_next == '0) ? MODE_HEADER : MODE_LITERAL;
				push_entry.run = 1'b1;
			end
			MODE_REPEAT: begin
				mode_d            = MODE_HEADER;
				push_entry.run    = 1'b1;
				push_entry.length = rep_len_q;
			end
			default: begin
				mode_d = MODE_HEADER;
			end
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HEADER;
			lit_left_q <= '0;
			rep_len_q  <= '0;
		end else if (accept) begin
			mode_q     <= mode_d;
			lit_left_q <= lit_left_d;
			rep_len_q  <= rep_len_d;
		end
	end

endmodule

/* sv/psd_queue.sv */
`timescale 1ns / 1ps

module psd_queue import psd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	input  q_entry_t push_entry,
	output logic     push_ready,
	output logic     pop_valid,
	output q_entry_t pop_entry,
	input  logic     pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t          slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* sv/psd_back.sv */
`timescale 1ns / 1ps

module psd_back import psd_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int MAX_STRIDE   = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	input  q_entry_t            pop_entry,
	output logic                pop,
	input  logic [STRIDE_W-1:0] stride,
	input  logic [ECNT_W-1:0]   elem_count,
	psd_out_if.source           runs
);

	localparam int LIM_MAX = (MAX_ELEMENTS < ECNT_REG_MAX) ? MAX_ELEMENTS : ECNT_REG_MAX;
	localparam int CNT_W   = $clog2(LIM_MAX + 1);
	localparam int STR_MAX = (MAX_STRIDE < STRIDE_REG_MAX) ? MAX_STRIDE : STRIDE_REG_MAX;
	localparam int STR_W   = $clog2(STR_MAX + 1);
	localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int PROD_W  = CNT_W + STR_W;
	localparam int SUM_W   = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;
	localparam int IDXE_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	logic [CNT_W-1:0]  written_q, written_d;
	logic [CH_W-1:0]   chan_q, chan_d;
	logic              done_q, done_d;

	logic [CNT_W-1:0]  lim, w0, left, w_new;
	logic [STR_W-1:0]  stride_lim;
	logic [CH_W-1:0]   c0;
	logic              d0, reached, emit, over, done_new, out_free;
	logic [LEN_W-1:0]  len_clip;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  addr_sum;
	logic [IDXE_W-1:0] idx_ext;

	logic              out_vld_q;
	logic [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]  index_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic              done_out_q, over_q;

	// Saturate the config values
	assign lim = (32'(elem_count) > LIM_MAX) ? CNT_W'(LIM_MAX) : CNT_W'(elem_count);
	assign stride_lim = (32'(stride) > STR_MAX) ? STR_W'(STR_MAX) : STR_W'(stride);

	// Output register frees when empty or when the word leaves
	assign out_free = !out_vld_q || runs.ready;
	assign pop      = pop_valid && out_free;

	// Run bookkeeping: clip, address, count update
	always_comb begin
		w0      = pop_entry.new_stream ? '0 : written_q;
		c0      = pop_entry.new_stream ? pop_entry.channel : chan_q;
		d0      = pop_entry.new_stream ? 1'b0 : done_q;
		reached = (w0 >= lim);
		emit    = pop_entry.run && !d0 && !reached;

		left     = lim - w0;
		over     = CMP_W'(pop_entry.length) > CMP_W'(left);
		len_clip = over ? LEN_W'(left) : pop_entry.length;
		w_new    = w0 + CNT_W'(len_clip);
		done_new = (w_new >= lim);

		prod     = PROD_W'(w0) * PROD_W'(stride_lim);
		addr_sum = SUM_W'(prod) + SUM_W'(c0);
		idx_ext  = IDXE_W'(w0);

		written_d = w0;
		chan_d    = c0;
		done_d    = d0 || reached;
		if (emit) begin
			written_d = w_new;
			done_d    = done_new;
		end
	end

	// Stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			chan_q    <= '0;
			done_q    <= 1'b0;
		end else if (pop) begin
			written_q <= written_d;
			chan_q    <= chan_d;
			done_q    <= done_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= pop && emit;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			value_q    <= pop_entry.value;
			index_q    <= idx_ext[IDX_W-1:0];
			addr_q     <= addr_sum[ADDR_W-1:0];
			len_q      <= len_clip;
			done_out_q <= done_new;
			over_q     <= over;
		end
	end

	assign runs.valid         = out_vld_q;
	assign runs.run_value     = value_q;
	assign runs.element_index = index_q;
	assign runs.byte_address  = addr_q;
	assign runs.run_length    = len_q;
	assign runs.stream_done   = done_out_q;
	assign runs.overrun       = over_q;

`ifndef SYNTHESIS
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (len_q != '0))
		else $error("run word with zero length");

	a_over_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && over_q) |-> done_out_q)
		else $error("clipped run without stream done");

	a_done_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(pop))
		else $error("stream done set without a queue pop");

	a_word_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(pop))
		else $error("run word appeared without a queue pop");
`endif

endmodule
